// ===== rtl/gbwb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gbwb_pkg;

  localparam int OFFSET_W            = 12;
  localparam int WEIGHT_W            = 8;
  localparam int MAX_RADIUS          = 1024;
  localparam int FALLOFF_TABLE_DEPTH = 256;
  localparam int IDX_W               = $clog2(FALLOFF_TABLE_DEPTH);

  localparam int RSQ_W  = 25;
  localparam int IRSQ_W = 24;
  localparam int STR_W  = 16;
  localparam int FALL_W = 16;
  localparam int RATIO_W = 16;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam int MAG_W  = OFFSET_W;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int D2_W   = $clog2(2 * MAX_RADIUS * MAX_RADIUS + 1);
  localparam int PROD_W = D2_W + IRSQ_W;
  localparam int BLEND_W = STR_W + FALL_W;
  localparam int DIFF_W = WEIGHT_W + 2;
  localparam int TERM_W = DIFF_W + BLEND_W + 1;
  localparam int FRAC_W = 28;
  localparam int VAL_W  = TERM_W + 1;

  localparam logic [1:0] REG_RADIUS_SQUARED         = 2'd0;
  localparam logic [1:0] REG_INVERSE_RADIUS_SQUARED = 2'd1;
  localparam logic [1:0] REG_STRENGTH               = 2'd2;
  localparam logic [1:0] REG_ERASE_MODE             = 2'd3;

  localparam logic [RSQ_W-1:0]  RSQ_RESET  = RSQ_W'(256);
  localparam logic [IRSQ_W-1:0] IRSQ_RESET = IRSQ_W'(65536);
  localparam logic [STR_W-1:0]  STR_RESET  = STR_W'(4096);

  typedef logic [FALL_W-1:0] falloff_rom_t [FALLOFF_TABLE_DEPTH];

  // exp(-4.5 * i / depth): cubic series on argument/256, then eight squarings
  function automatic falloff_rom_t build_falloff_rom();
    falloff_rom_t rom;
    logic [63:0]  one;
    logic [63:0]  x;
    logic [63:0]  z;
    logic [63:0]  z2;
    logic [63:0]  z3;
    logic [63:0]  e;
    logic [63:0]  r;
    one = 64'd1 << 31;
    for (int i = 0; i < FALLOFF_TABLE_DEPTH; i++) begin
      x  = ((64'd9 * 64'(i)) << 30) / 64'(FALLOFF_TABLE_DEPTH);
      z  = x >> 8;
      z2 = (z * z) >> 31;
      z3 = (z2 * z) >> 31;
      e  = one - z + (z2 >> 1) - (z3 / 64'd6);
      for (int k = 0; k < 8; k++) begin
        e = (e * e + (64'd1 << 30)) >> 31;
      end
      r = (e + (64'd1 << 14)) >> 15;
      rom[i] = (r > 64'd65535) ? {FALL_W{1'b1}} : r[FALL_W-1:0];
    end
    return rom;
  endfunction

  localparam falloff_rom_t FALLOFF_ROM = build_falloff_rom();

endpackage

`default_nettype wire

// ===== rtl/gaussian_brush_weight_blend_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  | valid         | stall         | payload
// ---------+---------------+---------------+------------------------------------
// sample   | sample_valid  | sample_stall  | offset_x, offset_y, weight_in
// result   | result_valid  | result_stall  | weight_out, inside_brush
// config   | psel/penable  | pready (1)    | paddr, pwdata, pwrite -> prdata
//
// One request per clock unless a held result stalls the pipeline.
// Seven register stages: squares, distance test, reciprocal multiply, falloff
// table, strength multiply, blend multiply, round and clamp.
// A held result freezes every stage; sample_stall follows at once.
// Reset empties the pipeline and loads the default brush registers.

module gaussian_brush_weight_blend_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [gbwb_pkg::CFG_ADDR_W-1:0]       paddr,
  input  wire logic [gbwb_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic      [gbwb_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                       pready,
  input  wire logic                                  sample_valid,
  output logic                                       sample_stall,
  input  wire logic signed [gbwb_pkg::OFFSET_W-1:0]  offset_x,
  input  wire logic signed [gbwb_pkg::OFFSET_W-1:0]  offset_y,
  input  wire logic [gbwb_pkg::WEIGHT_W-1:0]         weight_in,
  output logic                                       result_valid,
  input  wire logic                                  result_stall,
  output logic      [gbwb_pkg::WEIGHT_W-1:0]         weight_out,
  output logic                                       inside_brush
);

  logic [gbwb_pkg::RSQ_W-1:0]  radius_squared;
  logic [gbwb_pkg::IRSQ_W-1:0] inverse_radius_squared;
  logic [gbwb_pkg::STR_W-1:0]  strength;
  logic                        erase_mode;
  logic                        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_squared         <= gbwb_pkg::RSQ_RESET;
      inverse_radius_squared <= gbwb_pkg::IRSQ_RESET;
      strength               <= gbwb_pkg::STR_RESET;
      erase_mode             <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        gbwb_pkg::REG_RADIUS_SQUARED:
          radius_squared <= pwdata[gbwb_pkg::RSQ_W-1:0];
        gbwb_pkg::REG_INVERSE_RADIUS_SQUARED:
          inverse_radius_squared <= pwdata[gbwb_pkg::IRSQ_W-1:0];
        gbwb_pkg::REG_STRENGTH:
          strength <= pwdata[gbwb_pkg::STR_W-1:0];
        gbwb_pkg::REG_ERASE_MODE:
          erase_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      gbwb_pkg::REG_RADIUS_SQUARED:
        prdata = gbwb_pkg::CFG_DATA_W'(radius_squared);
      gbwb_pkg::REG_INVERSE_RADIUS_SQUARED:
        prdata = gbwb_pkg::CFG_DATA_W'(inverse_radius_squared);
      gbwb_pkg::REG_STRENGTH:
        prdata = gbwb_pkg::CFG_DATA_W'(strength);
      gbwb_pkg::REG_ERASE_MODE:
        prdata = gbwb_pkg::CFG_DATA_W'(erase_mode);
      default:
        prdata = '0;
    endcase
  end

  logic advance;
  assign advance      = !(result_valid && result_stall);
  assign sample_stall = !advance;

  // stage 1: range check and squares
  localparam logic signed [gbwb_pkg::OFFSET_W:0] MAX_R = (gbwb_pkg::OFFSET_W+1)'(
    gbwb_pkg::MAX_RADIUS);

  logic signed [gbwb_pkg::OFFSET_W:0] ext_x;
  logic signed [gbwb_pkg::OFFSET_W:0] ext_y;
  logic [gbwb_pkg::MAG_W-1:0]         mag_x;
  logic [gbwb_pkg::MAG_W-1:0]         mag_y;
  logic                               in_range;

  assign ext_x    = $signed({offset_x[gbwb_pkg::OFFSET_W-1], offset_x});
  assign ext_y    = $signed({offset_y[gbwb_pkg::OFFSET_W-1], offset_y});
  assign mag_x    = offset_x[gbwb_pkg::OFFSET_W-1] ? gbwb_pkg::MAG_W'(-offset_x)
                                                   : gbwb_pkg::MAG_W'(offset_x);
  assign mag_y    = offset_y[gbwb_pkg::OFFSET_W-1] ? gbwb_pkg::MAG_W'(-offset_y)
                                                   : gbwb_pkg::MAG_W'(offset_y);
  assign in_range = (ext_x <= MAX_R) && (ext_x >= -MAX_R) &&
                    (ext_y <= MAX_R) && (ext_y >= -MAX_R);

  logic                           v1;
  logic                           range1;
  logic [gbwb_pkg::SQ_W-1:0]      sq_x1;
  logic [gbwb_pkg::SQ_W-1:0]      sq_y1;
  logic [gbwb_pkg::WEIGHT_W-1:0]  w1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      range1 <= in_range;
      sq_x1  <= gbwb_pkg::SQ_W'(mag_x) * gbwb_pkg::SQ_W'(mag_x);
      sq_y1  <= gbwb_pkg::SQ_W'(mag_y) * gbwb_pkg::SQ_W'(mag_y);
      w1     <= weight_in;
    end
  end

  // stage 2: distance and radius test
  logic [gbwb_pkg::SQ_W:0]        d2_full;
  logic [gbwb_pkg::SQ_W+4:0]      d2_scaled;
  logic                           inside_now;

  assign d2_full    = (gbwb_pkg::SQ_W+1)'(sq_x1) + (gbwb_pkg::SQ_W+1)'(sq_y1);
  assign d2_scaled  = {d2_full, 4'b0000};
  assign inside_now = range1 && (d2_scaled <= (gbwb_pkg::SQ_W+5)'(radius_squared));

  logic                           v2;
  logic                           inside2;
  logic [gbwb_pkg::D2_W-1:0]      d2_2;
  logic [gbwb_pkg::WEIGHT_W-1:0]  w2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      inside2 <= inside_now;
      d2_2    <= d2_full[gbwb_pkg::D2_W-1:0];
      w2      <= w1;
    end
  end

  // stage 3: ratio product
  logic                           v3;
  logic                           inside3;
  logic [gbwb_pkg::PROD_W-1:0]    prod3;
  logic [gbwb_pkg::WEIGHT_W-1:0]  w3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (advance) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      inside3 <= inside2;
      prod3   <= gbwb_pkg::PROD_W'(d2_2) * gbwb_pkg::PROD_W'(inverse_radius_squared);
      w3      <= w2;
    end
  end

  // stage 4: saturate ratio, table lookup
  logic [gbwb_pkg::RATIO_W-1:0]   ratio;
  logic [31:0]                    idx_full;
  logic [gbwb_pkg::IDX_W-1:0]     idx;

  assign ratio    = (|prod3[gbwb_pkg::PROD_W-1:gbwb_pkg::RATIO_W+8])
                    ? {gbwb_pkg::RATIO_W{1'b1}}
                    : prod3[gbwb_pkg::RATIO_W+7:8];
  assign idx_full = 32'(ratio) * 32'(gbwb_pkg::FALLOFF_TABLE_DEPTH);
  assign idx      = idx_full[gbwb_pkg::RATIO_W +: gbwb_pkg::IDX_W];

  logic                           v4;
  logic                           inside4;
  logic [gbwb_pkg::FALL_W-1:0]    falloff4;
  logic [gbwb_pkg::WEIGHT_W-1:0]  w4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (advance) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      inside4  <= inside3;
      falloff4 <= gbwb_pkg::FALLOFF_ROM[idx];
      w4       <= w3;
    end
  end

  // stage 5: strength scale
  logic                           v5;
  logic                           inside5;
  logic [gbwb_pkg::BLEND_W-1:0]   blend5;
  logic [gbwb_pkg::WEIGHT_W-1:0]  w5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (advance) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      inside5 <= inside4;
      blend5  <= gbwb_pkg::BLEND_W'(strength) * gbwb_pkg::BLEND_W'(falloff4);
      w5      <= w4;
    end
  end

  // stage 6: blend toward target
  logic [gbwb_pkg::WEIGHT_W-1:0]      target;
  logic signed [gbwb_pkg::DIFF_W-1:0] diff;
  logic signed [gbwb_pkg::TERM_W-1:0] term_next;

  assign target    = erase_mode ? '0 : {gbwb_pkg::WEIGHT_W{1'b1}};
  assign diff      = $signed({2'b00, target}) - $signed({2'b00, w5});
  assign term_next = gbwb_pkg::TERM_W'(diff) *
                     gbwb_pkg::TERM_W'($signed({1'b0, blend5}));

  logic                               v6;
  logic                               inside6;
  logic signed [gbwb_pkg::TERM_W-1:0] term6;
  logic [gbwb_pkg::WEIGHT_W-1:0]      w6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (advance) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      inside6 <= inside5;
      term6   <= term_next;
      w6      <= w5;
    end
  end

  // stage 7: sum, round, clamp
  logic signed [gbwb_pkg::VAL_W-1:0] value;
  logic signed [gbwb_pkg::VAL_W-1:0] rounded;
  logic [gbwb_pkg::VAL_W-gbwb_pkg::FRAC_W-1:0] whole;
  logic [gbwb_pkg::WEIGHT_W-1:0]     blended;
  logic [gbwb_pkg::WEIGHT_W-1:0]     weight_out_next;

  assign value   = $signed(gbwb_pkg::VAL_W'({w6, {gbwb_pkg::FRAC_W{1'b0}}}))
                   + gbwb_pkg::VAL_W'(term6);
  assign rounded = value + $signed(gbwb_pkg::VAL_W'(1) <<< (gbwb_pkg::FRAC_W - 1));
  assign whole   = rounded[gbwb_pkg::VAL_W-1:gbwb_pkg::FRAC_W];

  always_comb begin
    if (value[gbwb_pkg::VAL_W-1]) begin
      blended = '0;
    end else if (|whole[gbwb_pkg::VAL_W-gbwb_pkg::FRAC_W-1:gbwb_pkg::WEIGHT_W]) begin
      blended = {gbwb_pkg::WEIGHT_W{1'b1}};
    end else begin
      blended = whole[gbwb_pkg::WEIGHT_W-1:0];
    end
    weight_out_next = inside6 ? blended : w6;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      inside_brush <= inside6;
      weight_out   <= weight_out_next;
    end
  end

`ifndef SYNTH
  a_stall_only_on_held_result: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (result_valid && result_stall))
    else $error("sample_stall without a held result");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result_valid set right after reset");

  a_pipe_frozen_on_stall: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> $stable({v1, v2, v3, v4, v5, v6}))
    else $error("pipeline stage valid moved during a stall");

  a_outside_passes_weight: assert property (@(posedge clk) disable iff (rst)
    (advance && v6 && !inside6) |=> (weight_out == $past(w6)))
    else $error("outside sample did not keep its weight");
`endif

endmodule

`default_nettype wire

// ===== verif/gbwb_tb_pkg.sv =====
`timescale 1ns / 1ps

package gbwb_tb_pkg;

  import gbwb_pkg::*;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                in_brush;
  } stamp_result_t;

  class brush_scoreboard;

    logic [FALL_W-1:0] falloff_lut [FALLOFF_TABLE_DEPTH];
    logic [RSQ_W-1:0]  radius_sq;
    logic [IRSQ_W-1:0] inv_radius_sq;
    logic [STR_W-1:0]  strength;
    logic              erase;
    stamp_result_t     pending_stamps [$];
    int unsigned       mismatch_count;

    function new();
      for (int i = 0; i < FALLOFF_TABLE_DEPTH; i++) begin
        falloff_lut[i] = gaussian_entry(i);
      end
      radius_sq      = RSQ_W'(256);
      inv_radius_sq  = IRSQ_W'(65536);
      strength       = STR_W'(4096);
      erase          = 1'b0;
      mismatch_count = 0;
    endfunction

    // exp(-4.5 * i / depth) in Q0.16: cubic series on arg/256, then eight squarings
    function logic [FALL_W-1:0] gaussian_entry(int unsigned i);
      logic [63:0] arg;
      logic [63:0] z;
      logic [63:0] z2;
      logic [63:0] z3;
      logic [63:0] e;
      logic [63:0] q;
      arg = (64'd9 * 64'(i) << 30) / 64'(FALLOFF_TABLE_DEPTH);
      z   = arg >> 8;
      z2  = (z * z) >> 31;
      z3  = (z2 * z) >> 31;
      e   = (64'd1 << 31) - z + z2 / 64'd2 - z3 / 64'd6;
      for (int k = 0; k < 8; k++) begin
        e = (e * e + (64'd1 << 30)) >> 31;
      end
      q = (e + (64'd1 << 14)) >> 15;
      return (q > 64'd65535) ? {FALL_W{1'b1}} : q[FALL_W-1:0];
    endfunction

    function void set_register(logic [1:0] index, logic [31:0] value);
      case (index)
        REG_RADIUS_SQUARED:         radius_sq     = value[RSQ_W-1:0];
        REG_INVERSE_RADIUS_SQUARED: inv_radius_sq = value[IRSQ_W-1:0];
        REG_STRENGTH:               strength      = value[STR_W-1:0];
        REG_ERASE_MODE:             erase         = value[0];
        default: ;
      endcase
    endfunction

    function stamp_result_t stamp_weight(logic signed [OFFSET_W-1:0] dx,
                                         logic signed [OFFSET_W-1:0] dy,
                                         logic [WEIGHT_W-1:0] w);
      longint        sx;
      longint        sy;
      longint        d2;
      longint        ratio;
      longint        blend;
      longint        target;
      longint        value;
      longint        rounded;
      stamp_result_t r;
      sx         = dx;
      sy         = dy;
      r.weight   = w;
      r.in_brush = 1'b0;
      if (sx > MAX_RADIUS || sx < -MAX_RADIUS || sy > MAX_RADIUS || sy < -MAX_RADIUS) begin
        return r;
      end
      d2 = sx * sx + sy * sy;
      if ((d2 << 4) > longint'(radius_sq)) begin
        return r;
      end
      ratio = (d2 * longint'(inv_radius_sq)) >> 8;
      if (ratio > 65535) begin
        ratio = 65535;
      end
      blend  = longint'(strength) *
               longint'(falloff_lut[(ratio * FALLOFF_TABLE_DEPTH) >> 16]);
      target = erase ? 0 : 255;
      value  = longint'(w) * (longint'(1) << 28) + (target - longint'(w)) * blend;
      if (value < 0) begin
        r.weight = '0;
      end else begin
        rounded  = (value + (longint'(1) << 27)) >> 28;
        r.weight = (rounded > 255) ? 8'd255 : rounded[WEIGHT_W-1:0];
      end
      r.in_brush = 1'b1;
      return r;
    endfunction

    function void note_sample(logic signed [OFFSET_W-1:0] dx,
                              logic signed [OFFSET_W-1:0] dy,
                              logic [WEIGHT_W-1:0] w);
      pending_stamps.push_back(stamp_weight(dx, dy, w));
    endfunction

    function void check_result(logic [WEIGHT_W-1:0] weight, logic brush_hit);
      stamp_result_t exp_r;
      if (pending_stamps.size() == 0) begin
        report($sformatf("result weight %0d inside_brush %0b with no request pending",
                         weight, brush_hit));
        return;
      end
      exp_r = pending_stamps.pop_front();
      if (weight !== exp_r.weight) begin
        report($sformatf("weight_out %0d, predicted %0d", weight, exp_r.weight));
      end
      if (brush_hit !== exp_r.in_brush) begin
        report($sformatf("inside_brush %0b, predicted %0b", brush_hit, exp_r.in_brush));
      end
    endfunction

    function int pending();
      return pending_stamps.size();
    endfunction

    function void report(string msg);
      $display("[%0t] brush check: %s", $time, msg);
      mismatch_count++;
    endfunction

  endclass

endpackage

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  import gbwb_pkg::*;
  import gbwb_tb_pkg::*;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]         paddr = '0;
  logic [CFG_DATA_W-1:0]         pwdata = '0;
  logic [CFG_DATA_W-1:0]         prdata;
  logic                          pready;
  logic                          sample_valid = 1'b0;
  logic                          sample_stall;
  logic signed [OFFSET_W-1:0]    offset_x = '0;
  logic signed [OFFSET_W-1:0]    offset_y = '0;
  logic [WEIGHT_W-1:0]           weight_in = '0;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  logic [WEIGHT_W-1:0]           weight_out;
  logic                          inside_brush;

  brush_scoreboard sb = new();
  int unsigned     sent_count = 0;
  bit              send_busy = 1'b0;

  gaussian_brush_weight_blend_top u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .offset_x     (offset_x),
    .offset_y     (offset_y),
    .weight_in    (weight_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .weight_out   (weight_out),
    .inside_brush (inside_brush)
  );

  always #4 clk = ~clk;

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      sb.check_result(weight_out, inside_brush);
    end
  end

  initial begin : drain
    int unsigned drained;
    int unsigned hold;
    bit          drain_busy;
    drained    = 0;
    drain_busy = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (drained % 40 == 0) begin
        drain_busy = ($urandom_range(0, 2) == 0);
      end
      hold = drain_busy ? 0 : $urandom_range(0, 12);
      // hold off long enough to back the pipeline up into the input
      if (drained == 300) begin
        hold = 120;
      end
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
      drained++;
    end
  end

  task automatic send_sample(logic signed [OFFSET_W-1:0] dx,
                             logic signed [OFFSET_W-1:0] dy,
                             logic [WEIGHT_W-1:0] w);
    int unsigned gap;
    if (sent_count % 40 == 0) begin
      send_busy = ($urandom_range(0, 2) == 0);
    end
    gap = send_busy ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    offset_x     <= dx;
    offset_y     <= dy;
    weight_in    <= w;
    do @(posedge clk); while (sample_stall);
    sb.note_sample(dx, dy, w);
    sent_count++;
  endtask

  task automatic random_sample(int reach);
    int                         sel;
    int                         lim;
    logic signed [OFFSET_W-1:0] dx;
    logic signed [OFFSET_W-1:0] dy;
    sel = $urandom_range(0, 9);
    lim = reach + 2;
    if (sel < 7) begin
      dx = OFFSET_W'(int'($urandom_range(0, 2 * lim)) - lim);
      dy = OFFSET_W'(int'($urandom_range(0, 2 * lim)) - lim);
    end else if (sel < 9) begin
      dx = OFFSET_W'($urandom);
      dy = OFFSET_W'($urandom);
    end else begin
      dx = OFFSET_W'(MAX_RADIUS - 1 + int'($urandom_range(0, 3)));
      dy = OFFSET_W'(int'($urandom_range(0, 2 * lim)) - lim);
      if ($urandom_range(0, 1)) dx = -dx;
      if ($urandom_range(0, 1)) begin
        {dx, dy} = {dy, dx};
      end
    end
    send_sample(dx, dy, WEIGHT_W'($urandom));
  endtask

  task automatic settle();
    sample_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] index, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({index, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_register(index, value);
    @(posedge clk);
  endtask

  task automatic run_phase(int unsigned rsq, int unsigned irsq, int unsigned str,
                           bit erase, int reach, int count);
    settle();
    write_register(REG_RADIUS_SQUARED, rsq);
    write_register(REG_INVERSE_RADIUS_SQUARED, irsq);
    write_register(REG_STRENGTH, str);
    write_register(REG_ERASE_MODE, 32'(erase));
    repeat (count) random_sample(reach);
  endtask

  initial begin : stimulus
    int          reach;
    int unsigned rsq;
    int unsigned irsq;
    int unsigned str;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_sample(0, 0, 0);
    send_sample(0, 0, 255);
    send_sample(0, 0, 128);
    send_sample(4, 0, 100);
    send_sample(-4, 0, 7);
    send_sample(0, 4, 0);
    send_sample(0, -4, 255);
    send_sample(3, 3, 50);
    send_sample(0, -5, 9);
    send_sample(-1, -1, 255);
    send_sample(2, 1, 1);
    send_sample(1, 2, 254);
    send_sample(-2048, -2048, 255);
    send_sample(2047, 2047, 0);
    send_sample(1024, 0, 33);
    send_sample(-1024, 0, 44);
    send_sample(1025, 0, 55);
    send_sample(0, -1025, 66);
    send_sample(-1025, 1025, 170);

    run_phase(0, 0, 65535, 1'b0, 0, 60);
    run_phase(16777216, 16, 4096, 1'b1, 1024, 100);
    run_phase(16777216, 16777215, 0, 1'b0, 1024, 60);
    run_phase(16777216, 0, 65535, 1'b1, 1024, 60);

    repeat (8) begin
      reach = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 1024);
      rsq   = reach * reach * 16 + $urandom_range(0, 32);
      rsq   = (rsq > 16) ? rsq - 16 : 0;
      if (rsq > 16777216) rsq = 16777216;
      if (reach == 0 || $urandom_range(0, 3) == 0) begin
        irsq = $urandom_range(0, 16777215);
      end else begin
        irsq = 16777216 / (reach * reach);
        if (irsq > 16777215) irsq = 16777215;
      end
      str = ($urandom_range(0, 1)) ? $urandom_range(0, 65535) : $urandom_range(0, 8192);
      run_phase(rsq, irsq, str, 1'($urandom_range(0, 1)), reach, 80);
    end

    settle();
    if (sb.mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== gaussian_brush_weight_blend_top.f =====
rtl/gbwb_pkg.sv
rtl/gaussian_brush_weight_blend_top.sv
verif/gbwb_tb_pkg.sv
verif/tb_top.sv
